[src/dfr_pkg.sv]
package dfr_pkg;

  // width of the title, line and character counters
  localparam int COUNT_WIDTH = 32;

  // depth of the event queue between parser and expander
  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_AW    = $clog2(EVQ_DEPTH);
  localparam int EVQ_CW    = $clog2(EVQ_DEPTH + 1);

  // register indexes
  localparam logic CFG_FILE_TYPE  = 1'b0;
  localparam logic CFG_END_MARKER = 1'b1;

  // register reset values
  localparam logic [31:0] FILE_TYPE_RST  = 32'd30;
  localparam logic [31:0] END_MARKER_RST = 32'h0046_4F45;

  // parse status codes
  localparam logic [1:0] ST_PARSING = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;

  // line end units
  localparam logic [15:0] CU_CR = 16'd13;
  localparam logic [15:0] CU_LF = 16'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic [1:0]  parse_status;
    logic        last_of_run;
  } out_item_t;

  // one parser event: expands into one to three results
  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_char;
    logic        has_crlf;
    logic        is_status;
    logic [1:0]  status;
  } ev_t;

  // clamp a 32-bit count word to the counter width
  function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [31:0] w);
    logic [32:0] wide;
    wide = {1'b0, w};
    if ((wide >> COUNT_WIDTH) != 33'd0) begin
      return '1;
    end
    return wide[COUNT_WIDTH-1:0];
  endfunction

endpackage

[src/dfr_front.sv]
module dfr_front
  import dfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  in_item_t    item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        ev_push,
  output ev_t         ev
);

  // parser phases
  localparam logic [2:0] PH_TYPE   = 3'd0;
  localparam logic [2:0] PH_TSIZE  = 3'd1;
  localparam logic [2:0] PH_TITLE  = 3'd2;
  localparam logic [2:0] PH_LCOUNT = 3'd3;
  localparam logic [2:0] PH_LNUM   = 3'd4;
  localparam logic [2:0] PH_CCOUNT = 3'd5;
  localparam logic [2:0] PH_CHARS  = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  logic [31:0]            file_type_r;
  logic [31:0]            end_marker_r;
  logic [2:0]             phase_r,   phase_nxt,   phase_e;
  logic [31:0]            ws_r,      ws_nxt,      ws_e;
  logic [1:0]             bif_r,     bif_nxt,     bif_e;
  logic [COUNT_WIDTH-1:0] cr_r,      cr_nxt,      cr_e;
  logic [7:0]             hb_r,      hb_nxt,      hb_e;
  logic [COUNT_WIDTH-1:0] lr_r,      lr_nxt,      lr_e;
  logic [31:0]            word;
  logic [1:0]             bif_inc;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cr_dec;
  logic [COUNT_WIDTH-1:0] lr_dec;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_type_r  <= FILE_TYPE_RST;
      end_marker_r <= END_MARKER_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FILE_TYPE) begin
        file_type_r <= cfg_wdata;
      end else begin
        end_marker_r <= cfg_wdata;
      end
    end
  end

  // new_file restarts the parser before this byte is taken
  always_comb begin
    phase_e = item.new_file ? PH_TYPE : phase_r;
    ws_e    = item.new_file ? 32'd0 : ws_r;
    bif_e   = item.new_file ? 2'd0 : bif_r;
    cr_e    = item.new_file ? '0 : cr_r;
    hb_e    = item.new_file ? 8'd0 : hb_r;
    lr_e    = item.new_file ? '0 : lr_r;
  end

  assign word    = {ws_e[23:0], item.data_byte};
  assign bif_inc = bif_e + 2'd1;
  assign cnt     = sat_count(word);
  assign cr_dec  = cr_e - 1'b1;
  assign lr_dec  = lr_e - 1'b1;

  // field state machine, one byte per transfer
  always_comb begin
    phase_nxt = phase_r;
    ws_nxt    = ws_r;
    bif_nxt   = bif_r;
    cr_nxt    = cr_r;
    hb_nxt    = hb_r;
    lr_nxt    = lr_r;
    ev_push   = 1'b0;
    ev        = '0;
    if (accept) begin
      phase_nxt = phase_e;
      ws_nxt    = ws_e;
      bif_nxt   = bif_e;
      cr_nxt    = cr_e;
      hb_nxt    = hb_e;
      lr_nxt    = lr_e;
      case (phase_e)
        PH_TYPE, PH_TSIZE, PH_LCOUNT, PH_LNUM, PH_CCOUNT: begin
          ws_nxt  = word;
          bif_nxt = bif_inc;
          if (bif_inc == 2'd0) begin
            ws_nxt = 32'd0;
            case (phase_e)
              PH_TYPE: begin
                if (word != file_type_r) begin
                  phase_nxt    = PH_DONE;
                  ev_push      = 1'b1;
                  ev.is_status = 1'b1;
                  ev.status    = ST_REJECT;
                end else begin
                  phase_nxt = PH_TSIZE;
                end
              end
              PH_TSIZE: begin
                cr_nxt    = cnt;
                phase_nxt = (cnt == '0) ? PH_LCOUNT : PH_TITLE;
              end
              PH_LCOUNT: begin
                lr_nxt = cnt;
                if (cnt == '0) begin
                  phase_nxt    = PH_DONE;
                  ev_push      = 1'b1;
                  ev.is_status = 1'b1;
                  ev.status    = ST_DONE;
                end else begin
                  phase_nxt = PH_LNUM;
                end
              end
              PH_LNUM: begin
                if (word == end_marker_r) begin
                  phase_nxt    = PH_DONE;
                  ev_push      = 1'b1;
                  ev.is_status = 1'b1;
                  ev.status    = ST_DONE;
                end else begin
                  phase_nxt = PH_CCOUNT;
                end
              end
              default: begin
                // character count word: an empty line ends at once
                cr_nxt = cnt;
                if (cnt == '0) begin
                  ev_push     = 1'b1;
                  ev.has_crlf = 1'b1;
                  lr_nxt      = lr_dec;
                  if (lr_dec == '0) begin
                    phase_nxt = PH_DONE;
                    ev.status = ST_DONE;
                  end else begin
                    phase_nxt = PH_LNUM;
                  end
                end else begin
                  phase_nxt = PH_CHARS;
                end
              end
            endcase
          end
        end
        PH_TITLE: begin
          if (bif_e == 2'd0) begin
            bif_nxt = 2'd1;
          end else begin
            bif_nxt = 2'd0;
            cr_nxt  = cr_dec;
            if (cr_dec == '0) begin
              phase_nxt = PH_LCOUNT;
            end
          end
        end
        PH_CHARS: begin
          if (bif_e == 2'd0) begin
            hb_nxt  = item.data_byte;
            bif_nxt = 2'd1;
          end else begin
            bif_nxt      = 2'd0;
            ev_push      = 1'b1;
            ev.has_char  = 1'b1;
            ev.code_unit = {hb_e, item.data_byte};
            cr_nxt       = cr_dec;
            if (cr_dec == '0) begin
              ev.has_crlf = 1'b1;
              lr_nxt      = lr_dec;
              if (lr_dec == '0) begin
                phase_nxt = PH_DONE;
                ev.status = ST_DONE;
              end else begin
                phase_nxt = PH_LNUM;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      ws_r    <= 32'd0;
      bif_r   <= 2'd0;
      cr_r    <= '0;
      hb_r    <= 8'd0;
      lr_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      ws_r    <= ws_nxt;
      bif_r   <= bif_nxt;
      cr_r    <= cr_nxt;
      hb_r    <= hb_nxt;
      lr_r    <= lr_nxt;
    end
  end

endmodule

[src/dfr_evq.sv]
module dfr_evq
  import dfr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ev_t  push_ev,
  input  logic pop,
  output ev_t  head,
  output logic empty,
  output logic full
);

  ev_t               mem [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wp_r, wp_nxt;
  logic [EVQ_AW-1:0] rp_r, rp_nxt;
  logic [EVQ_CW-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == EVQ_CW'(EVQ_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rp_r];

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == EVQ_AW'(EVQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= push_ev;
    end
  end

endmodule

[src/dfr_back.sv]
module dfr_back
  import dfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ev_t       head,
  input  logic      head_valid,
  output logic      head_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  logic [1:0] step_r, step_nxt;
  logic [1:0] crlf_pos;
  out_item_t  res;
  out_item_t  out_r;
  logic       out_valid_r;
  logic       load;

  assign crlf_pos = step_r - {1'b0, head.has_char};

  // pick the result for the current step of the head event
  always_comb begin
    res              = '0;
    res.parse_status = head.status;
    if (head.is_status) begin
      res.last_of_run = 1'b1;
    end else if (head.has_char && (step_r == 2'd0)) begin
      res.code_unit   = head.code_unit;
      res.unit_valid  = 1'b1;
      res.last_of_run = !head.has_crlf;
    end else begin
      res.unit_valid  = 1'b1;
      res.code_unit   = (crlf_pos == 2'd0) ? CU_CR : CU_LF;
      res.last_of_run = (crlf_pos != 2'd0);
    end
  end

  assign load     = head_valid && (!out_valid_r || out_pop);
  assign head_pop = load && res.last_of_run;

  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = res.last_of_run ? 2'd0 : step_r + 2'd1;
    end
  end

  // step counter and output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

endmodule

[src/utf16_note_record_deframer.sv]
// Deframes a big-endian note record file arriving one byte per transfer and
// delivers 16-bit text units, with CR and LF closing every line, plus status
// results on reject or finish. The parser takes one byte each cycle while
// the four-entry event queue that parts input and output is not full; each
// byte causes zero to three results, which pass through the queue and then
// leave one per cycle from an output register while the receiver pops. The
// input reports full only when the queue is full, which happens when
// results (up to three per byte) arrive faster than they are drained.
module utf16_note_record_deframer
  import dfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  in_item_t    in_item,
  output logic        in_full,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic accept;
  logic ev_push;
  ev_t  ev;
  ev_t  head;
  logic evq_empty;
  logic evq_full;
  logic head_pop;

  assign in_full = evq_full;
  assign accept  = in_push && !evq_full;

  // byte parser
  dfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ev_push   (ev_push),
    .ev        (ev)
  );

  // event queue
  dfr_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ev_push),
    .push_ev (ev),
    .pop     (head_pop),
    .head    (head),
    .empty   (evq_empty),
    .full    (evq_full)
  );

  // result expander
  dfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!evq_empty),
    .head_pop   (head_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_item   (out_item)
  );

endmodule

[tb/sv/utf16_note_record_deframer_test.sv]
`timescale 1ns / 100ps

module utf16_note_record_deframer_test;
  import dfr_pkg::*;

  typedef enum logic [2:0] {
    P_TYPE, P_TSIZE, P_TITLE, P_LCOUNT, P_LNUM, P_CCOUNT, P_CHARS, P_DONE
  } parse_phase_t;

  // tracks the parser, predicts the text units of each byte and checks them in order
  class deframe_scoreboard;
    logic [31:0]            file_type;
    logic [31:0]            end_marker;
    parse_phase_t           phase;
    logic [31:0]            word_acc;
    logic [1:0]             byte_pos;
    logic [COUNT_WIDTH-1:0] chars_left;
    logic [COUNT_WIDTH-1:0] lines_left;
    logic [7:0]             hi_byte;
    out_item_t              byte_units[$];
    out_item_t              expected_units[$];
    int                     error_count;

    function new();
      file_type   = FILE_TYPE_RST;
      end_marker  = END_MARKER_RST;
      error_count = 0;
      restart();
    endfunction

    function void restart();
      phase      = P_TYPE;
      word_acc   = '0;
      byte_pos   = '0;
      chars_left = '0;
      lines_left = '0;
      hi_byte    = '0;
    endfunction

    function void write_reg(logic reg_index, logic [31:0] reg_value);
      if (reg_index == CFG_FILE_TYPE) begin
        file_type = reg_value;
      end else begin
        end_marker = reg_value;
      end
    endfunction

    // counts wider than the counters stick at all ones
    function logic [COUNT_WIDTH-1:0] clamp_count(logic [31:0] w);
      logic [63:0] wide;
      wide = {32'd0, w};
      if ((wide >> COUNT_WIDTH) != 64'd0) return '1;
      return wide[COUNT_WIDTH-1:0];
    endfunction

    function void add_unit(logic [15:0] code, logic valid);
      out_item_t u;
      u = '0;
      u.code_unit  = code;
      u.unit_valid = valid;
      byte_units.push_back(u);
    endfunction

    // CR LF, then the next line or the end of the file
    function logic [1:0] close_line();
      add_unit(CU_CR, 1'b1);
      add_unit(CU_LF, 1'b1);
      lines_left = lines_left - 1'b1;
      if (lines_left == '0) begin
        phase = P_DONE;
        return ST_DONE;
      end
      phase = P_LNUM;
      return ST_PARSING;
    endfunction

    function void take_byte(in_item_t it);
      logic [1:0]  status;
      logic [31:0] word;
      status = ST_PARSING;
      byte_units.delete();
      if (it.new_file) restart();
      case (phase)
        P_TITLE: begin
          if (byte_pos == 2'd0) begin
            byte_pos = 2'd1;
          end else begin
            byte_pos   = 2'd0;
            chars_left = chars_left - 1'b1;
            if (chars_left == '0) phase = P_LCOUNT;
          end
        end
        P_CHARS: begin
          if (byte_pos == 2'd0) begin
            hi_byte  = it.data_byte;
            byte_pos = 2'd1;
          end else begin
            byte_pos = 2'd0;
            add_unit({hi_byte, it.data_byte}, 1'b1);
            chars_left = chars_left - 1'b1;
            if (chars_left == '0) status = close_line();
          end
        end
        P_DONE: ;
        default: begin
          // 32-bit header and record words, most significant byte first
          word_acc = {word_acc[23:0], it.data_byte};
          byte_pos = byte_pos + 2'd1;
          if (byte_pos == 2'd0) begin
            word     = word_acc;
            word_acc = '0;
            case (phase)
              P_TYPE: begin
                if (word != file_type) begin
                  phase = P_DONE;
                  add_unit(16'd0, 1'b0);
                  status = ST_REJECT;
                end else begin
                  phase = P_TSIZE;
                end
              end
              P_TSIZE: begin
                chars_left = clamp_count(word);
                phase = (chars_left == '0) ? P_LCOUNT : P_TITLE;
              end
              P_LCOUNT: begin
                lines_left = clamp_count(word);
                if (lines_left == '0) begin
                  phase = P_DONE;
                  add_unit(16'd0, 1'b0);
                  status = ST_DONE;
                end else begin
                  phase = P_LNUM;
                end
              end
              P_LNUM: begin
                if (word == end_marker) begin
                  phase = P_DONE;
                  add_unit(16'd0, 1'b0);
                  status = ST_DONE;
                end else begin
                  phase = P_CCOUNT;
                end
              end
              default: begin
                chars_left = clamp_count(word);
                if (chars_left == '0) status = close_line();
                else phase = P_CHARS;
              end
            endcase
          end
        end
      endcase
      foreach (byte_units[k]) begin
        byte_units[k].parse_status = status;
        byte_units[k].last_of_run  = (k == byte_units.size() - 1);
        expected_units.push_back(byte_units[k]);
      end
    endfunction

    task report_mismatch(string what);
      error_count++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_unit(out_item_t got);
      out_item_t want;
      if (expected_units.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got));
        return;
      end
      want = expected_units.pop_front();
      if (got.code_unit !== want.code_unit)
        report_mismatch($sformatf("code_unit %h, expected %h", got.code_unit, want.code_unit));
      if (got.unit_valid !== want.unit_valid)
        report_mismatch($sformatf("unit_valid %b, expected %b", got.unit_valid,
                                  want.unit_valid));
      if (got.parse_status !== want.parse_status)
        report_mismatch($sformatf("parse_status %0d, expected %0d", got.parse_status,
                                  want.parse_status));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b, expected %b", got.last_of_run,
                                  want.last_of_run));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  in_item_t    in_item;
  logic        in_full;
  logic        out_empty;
  logic        out_pop;
  out_item_t   out_item;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  deframe_scoreboard sb;
  logic [7:0]        file_bytes[$];
  int                send_gap_pct;
  int                recv_stall_pct;
  int                random_bytes;
  bit                no_gaps;
  bit                hold_off_req;

  utf16_note_record_deframer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: check every transfer
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_unit(out_item);
  end

  // result side: pop with random stall bursts and one long hold-off on request
  initial begin
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_pop <= 1'b0;
        repeat (150) @(negedge clk);
        hold_off_req = 1'b0;
        out_pop <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_pop <= 1'b1;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // file image builders, big-endian
  function automatic void put_word(logic [31:0] w);
    file_bytes.push_back(w[31:24]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
  endfunction

  function automatic void put_unit(logic [15:0] u);
    file_bytes.push_back(u[15:8]);
    file_bytes.push_back(u[7:0]);
  endfunction

  // one line record with a number that is not the end marker
  function automatic void put_line();
    logic [31:0] lnum;
    int          n;
    lnum = $urandom_range(0, 1) ? $urandom_range(0, 999) : $urandom;
    if (lnum == sb.end_marker) lnum = ~lnum;
    n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
    put_word(lnum);
    put_word(n);
    repeat (n) put_unit(16'($urandom));
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_byte(in_item_t it);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    sb.take_byte(it);
    @(negedge clk);
  endtask

  task automatic send_stream(bit mark_start, bit noisy);
    in_item_t it;
    foreach (file_bytes[i]) begin
      it.data_byte = file_bytes[i];
      it.new_file  = (mark_start && i == 0) || (noisy && $urandom_range(0, 15) == 0);
      send_byte(it);
    end
    file_bytes.delete();
  endtask

  // mostly well-formed files with random content, some broken ones and noise
  task automatic send_random_file();
    int          title_len;
    int          lines;
    int          mode;
    int          keep;
    logic [31:0] type_word;
    send_gap_pct   = no_gaps ? 0 : $urandom_range(0, 2) * 12;
    recv_stall_pct = no_gaps ? 0 : $urandom_range(0, 2) * 12;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 12)) file_bytes.push_back(8'($urandom));
      send_stream(1'b0, 1'b1);
      return;
    end
    type_word = sb.file_type;
    if ($urandom_range(0, 9) == 0) type_word ^= 32'd1 << $urandom_range(0, 31);
    put_word(type_word);
    title_len = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
    put_word(title_len);
    repeat (title_len) put_unit(16'($urandom));
    mode = $urandom_range(0, 9);
    if (mode == 6) begin
      put_word(32'd0);
    end else if (mode >= 7 && mode <= 8) begin
      // huge line count, ended by the marker
      put_word($urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000));
      repeat ($urandom_range(0, 3)) put_line();
      put_word(sb.end_marker);
    end else begin
      lines = $urandom_range(1, 4);
      put_word(lines);
      repeat (lines) put_line();
      if (mode == 9) begin
        // cut short, sometimes inside a line with a huge character count
        if ($urandom_range(0, 1)) begin
          put_word($urandom_range(0, 999));
          put_word(32'hFFFF_FF00 | $urandom_range(0, 255));
          put_unit(16'($urandom));
        end else begin
          keep = $urandom_range(1, file_bytes.size() - 1);
          while (file_bytes.size() > keep) void'(file_bytes.pop_back());
        end
      end
    end
    random_bytes += file_bytes.size();
    // trailing bytes after the end are ignored
    if (mode != 9 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
    send_stream(1'b1, 1'b0);
  endtask

  task automatic run_random(int target);
    random_bytes = 0;
    while (random_bytes < target) send_random_file();
  endtask

  // all results delivered and the parser given time to settle
  task automatic wait_idle();
    in_push <= 1'b0;
    while (sb.expected_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [31:0] type_word, logic [31:0] marker);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILE_TYPE;
    cfg_wdata <= type_word;
    @(posedge clk);
    sb.write_reg(CFG_FILE_TYPE, type_word);
    @(negedge clk);
    cfg_index <= CFG_END_MARKER;
    cfg_wdata <= marker;
    @(posedge clk);
    sb.write_reg(CFG_END_MARKER, marker);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_push        = 1'b0;
    in_item        = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FILE_TYPE;
    cfg_wdata      = '0;
    send_gap_pct   = 12;
    recv_stall_pct = 12;
    random_bytes   = 0;
    no_gaps        = 1'b0;
    hold_off_req   = 1'b0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // wrong type word, then bytes that must be ignored
    put_word(32'h0000_001F);
    file_bytes.push_back(8'hAA);
    file_bytes.push_back(8'h55);
    send_stream(1'b1, 1'b0);
    // zero line count
    put_word(FILE_TYPE_RST);
    put_word(32'd0);
    put_word(32'd0);
    send_stream(1'b1, 1'b0);
    // skipped title, one character line, then an empty last line
    put_word(FILE_TYPE_RST);
    put_word(32'd2);
    put_unit(16'hFFFF);
    put_unit(16'h0000);
    put_word(32'd2);
    put_word(32'd7);
    put_word(32'd1);
    put_unit(16'hFFFF);
    put_word(32'd8);
    put_word(32'd0);
    send_stream(1'b1, 1'b0);
    // all-ones line count, ended by the marker
    put_word(FILE_TYPE_RST);
    put_word(32'd0);
    put_word(32'hFFFF_FFFF);
    put_word(32'hFFFF_FFFF);
    put_word(32'd2);
    put_unit(16'h8001);
    put_unit(16'h7FFE);
    put_word(END_MARKER_RST);
    send_stream(1'b1, 1'b0);
    // huge title cut off by a new file
    put_word(FILE_TYPE_RST);
    put_word(32'hFFFF_FFFF);
    file_bytes.push_back(8'h12);
    file_bytes.push_back(8'h34);
    file_bytes.push_back(8'h56);
    send_stream(1'b1, 1'b0);
    // huge character count cut off by a new file in the middle of a word
    put_word(FILE_TYPE_RST);
    put_word(32'd0);
    put_word(32'd1);
    put_word(32'd5);
    put_word(32'hFFFF_FFFF);
    put_unit(16'h1234);
    send_stream(1'b1, 1'b0);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h00);
    send_stream(1'b1, 1'b0);
    wait_idle();

    program_regs(32'h0000_0000, 32'hFFFF_FFFF);
    run_random(20);
    wait_idle();

    program_regs(32'hFFFF_FFFF, 32'h0000_0000);
    run_random(20);
    wait_idle();

    // receiver holds off while short lines keep coming, so the input stalls
    program_regs($urandom, $urandom);
    hold_off_req = 1'b1;
    send_gap_pct = 0;
    put_word(sb.file_type);
    put_word(32'd0);
    put_word(32'd8);
    repeat (8) begin
      put_word(~sb.end_marker);
      put_word(32'd1);
      put_unit(16'($urandom));
    end
    send_stream(1'b1, 1'b0);
    run_random(20);
    wait_idle();

    // back to reset values, no idling in the tail
    program_regs(FILE_TYPE_RST, END_MARKER_RST);
    no_gaps = 1'b1;
    run_random(20);

    in_push <= 1'b0;
    while (sb.expected_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
src/dfr_pkg.sv
src/dfr_front.sv
src/dfr_evq.sv
src/dfr_back.sv
src/utf16_note_record_deframer.sv
tb/sv/utf16_note_record_deframer_test.sv
